>>> rtl/bdla_pkg.sv
// package: shared types, codes and constants of the block directory
`timescale 1ns / 1ps
package bdla_pkg;

   localparam int NUM_SLOTS_DEF  = 64;
   localparam int SLOT_BYTES_DEF = 32;

   localparam int OPCODE_W = 2;
   localparam int ID_W     = 16;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 11;
   localparam int NF_W     = 6;
   // slot index width for the largest directory size
   localparam int IDX_W    = 8;

   localparam logic [ID_W-1:0] FREE_ID = 16'hFFFF;

   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic             active;
      logic [ID_W-1:0]  id;
      logic             found;
      logic [IDX_W-1:0] hit;
      logic [IDX_W-1:0] nf;
   } scan_pkt_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [ID_W-1:0]  id;
   } wr_req_type;

endpackage

>>> rtl/bdla_cell.sv
// one directory slot: holds its id and updates the passing scan packet
`timescale 1ns / 1ps
module bdla_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdla_pkg::scan_pkt_type pkt_in,
   output bdla_pkg::scan_pkt_type pkt_out,
   input  bdla_pkg::wr_req_type   wr
);
   import bdla_pkg::*;

   logic [ID_W-1:0] id_ff;
   scan_pkt_type    pkt_ff;
   scan_pkt_type    pkt_in_nxt;

   always_comb begin
      pkt_in_nxt = pkt_in;
      if (pkt_in.active) begin
         if (id_ff == pkt_in.id) begin
            pkt_in_nxt.found = 1'b1;
            pkt_in_nxt.hit   = IDX_W'(INDEX);
         end
         if ((INDEX != 0) && (pkt_in.nf == '0) && (id_ff == FREE_ID)) begin
            pkt_in_nxt.nf = IDX_W'(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff         <= FREE_ID;
         pkt_ff.active <= 1'b0;
      end else begin
         pkt_ff <= pkt_in_nxt;
         if (wr.en && (wr.idx == IDX_W'(INDEX))) begin
            id_ff <= wr.id;
         end
      end
   end

   assign pkt_out = pkt_ff;

endmodule

>>> rtl/bdla_ctrl.sv
// control: launches scans, forms the result and the slot update
`timescale 1ns / 1ps
module bdla_ctrl #(
   parameter int NUM_SLOTS  = bdla_pkg::NUM_SLOTS_DEF,
   parameter int SLOT_BYTES = bdla_pkg::SLOT_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bdla_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [bdla_pkg::ID_W-1:0]          req_block_id,
   input  logic [bdla_pkg::SLOT_W-1:0]        req_slot,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bdla_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bdla_pkg::ADDR_W-1:0]        rsp_byte_address,
   output logic [bdla_pkg::NF_W-1:0]          rsp_next_free,
   output bdla_pkg::scan_pkt_type             launch,
   input  bdla_pkg::scan_pkt_type             done_pkt,
   output bdla_pkg::wr_req_type               wr
);
   import bdla_pkg::*;

   localparam int PROD_W = IDX_W + 9;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   logic [OPCODE_W-1:0]     op_ff;
   logic [ID_W-1:0]         id_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [NF_W-1:0]         nf_ff, nf_in;

   logic                    req_xfer;
   logic                    scan_done;
   logic                    slot_ok;
   logic                    use_addr;
   logic [IDX_W-1:0]        addr_idx;
   logic [PROD_W-1:0]       addr_prod;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign scan_done = (state_ff == S_SCAN) && done_pkt.active;
   assign slot_ok   = (9'(slot_ff) < 9'(NUM_SLOTS));

   always_comb begin
      launch        = '0;
      launch.active = req_xfer;
      launch.id     = req_block_id;
   end

   always_comb begin
      status_in = ST_MISSING;
      use_addr  = 1'b0;
      addr_idx  = done_pkt.nf;
      nf_in     = done_pkt.nf[NF_W-1:0];
      wr        = '0;
      wr.id     = id_ff;
      wr.idx    = done_pkt.nf;
      unique case (op_ff)
         OP_LOAD: begin
            if (slot_ok) begin
               status_in = ST_OK;
               use_addr  = 1'b1;
               addr_idx  = IDX_W'(slot_ff);
               wr.en     = scan_done;
               wr.idx    = IDX_W'(slot_ff);
            end else begin
               status_in = ST_INVALID;
            end
         end
         default: begin
            if (id_ff == FREE_ID) begin
               status_in = ST_INVALID;
               nf_in     = '0;
            end else if (done_pkt.found) begin
               status_in = ST_OK;
               use_addr  = 1'b1;
               addr_idx  = done_pkt.hit;
            end else if (op_ff == OP_WRITE) begin
               if (done_pkt.nf == '0) begin
                  status_in = ST_FULL;
                  nf_in     = '0;
               end else begin
                  status_in = ST_OK;
                  use_addr  = 1'b1;
                  wr.en     = scan_done;
               end
            end
         end
      endcase
      addr_prod = PROD_W'(addr_idx) * PROD_W'(SLOT_BYTES);
      addr_in   = use_addr ? addr_prod[ADDR_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_SCAN;
                  op_ff    <= req_opcode;
                  id_ff    <= req_block_id;
                  slot_ff  <= req_slot;
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= status_in;
                  addr_ff      <= addr_in;
                  nf_ff        <= nf_in;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_byte_address = addr_ff;
   assign rsp_next_free    = nf_ff;

   a_wr_at_scan_end: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> scan_done)
      else $error("slot update outside scan end");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_SCAN) && !rsp_valid)
      else $error("transfer did not start a scan");

   a_result_marks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_RESP))
      else $error("result shown outside response state");

   a_full_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_byte_address == '0)
         && (rsp_next_free == '0))
      else $error("full result carries an address");

endmodule

>>> rtl/block_directory_lookup_alloc.sv
// top level: block directory as a chain of slot cells with a scan controller
//
// channel   direction  fields
// req_      in         opcode, block_id, slot
// rsp_      out        status, byte_address, next_free
//
// each request sends one scan packet through NUM_SLOTS slot cells, one cell per cycle
// the slot update, if any, is made at the edge the scan leaves the last cell
// reset frees every slot at once; one request is in flight at a time
// a stalled result holds the block; req_ready stays low until it is taken
`timescale 1ns / 1ps
module block_directory_lookup_alloc #(
   parameter int NUM_SLOTS  = bdla_pkg::NUM_SLOTS_DEF,
   parameter int SLOT_BYTES = bdla_pkg::SLOT_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bdla_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [bdla_pkg::ID_W-1:0]     req_block_id,
   input  logic [bdla_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bdla_pkg::STATUS_W-1:0] rsp_status,
   output logic [bdla_pkg::ADDR_W-1:0]   rsp_byte_address,
   output logic [bdla_pkg::NF_W-1:0]     rsp_next_free
);
   import bdla_pkg::*;

   scan_pkt_type chain [NUM_SLOTS+1];
   wr_req_type   wr;

   bdla_ctrl #(
      .NUM_SLOTS  (NUM_SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_block_id     (req_block_id),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_byte_address (rsp_byte_address),
      .rsp_next_free    (rsp_next_free),
      .launch           (chain[0]),
      .done_pkt         (chain[NUM_SLOTS]),
      .wr               (wr)
   );

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      bdla_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .pkt_in  (chain[i]),
         .pkt_out (chain[i+1]),
         .wr      (wr)
      );
   end

endmodule

>>> tb/tb_top.sv
// testbench: block directory lookup, allocation and slot load checked against a scan predictor
`timescale 1ns / 1ps
module tb_top;
   import bdla_pkg::*;

   localparam int NUM_SLOTS      = NUM_SLOTS_DEF;
   localparam int SLOT_BYTES     = SLOT_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TAIL_CYCLES    = 100;
   localparam int REQ_TARGET     = 1050;
   localparam int MAX_REPORTS    = 10;

   // opcode 3 is unused and behaves as a lookup
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ID_W-1:0]     block_id;
      logic [SLOT_W-1:0]   slot;
   } dir_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   byte_address;
      logic [NF_W-1:0]     next_free;
   } dir_rsp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_LOOKUP;
   logic [ID_W-1:0]     req_block_id = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_byte_address;
   logic [NF_W-1:0]     rsp_next_free;

   dir_req_type     pending_reqs[$];
   dir_rsp_type     expected_rsps[$];
   logic [ID_W-1:0] dir_ids[NUM_SLOTS];

   int mismatch_count = 0;
   int rsp_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   int holdoff_left = 0;
   int next_holdoff_at = 150;
   int rx_cycle = 0;
   int rx_mode = 0;
   int idle_cycles = 0;

   block_directory_lookup_alloc #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_BYTES(SLOT_BYTES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_block_id    (req_block_id),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_byte_address(rsp_byte_address),
      .rsp_next_free   (rsp_next_free)
   );

   // scan the directory, then apply the operation and return its result
   function automatic dir_rsp_type resolve_request(input dir_req_type rq);
      dir_rsp_type r;
      logic        found;
      int          hit;
      int          nf;
      int          i;
      found = 1'b0;
      hit   = 0;
      nf    = 0;
      for (i = 0; i < NUM_SLOTS; i++) begin
         if (dir_ids[i] == rq.block_id) begin
            found = 1'b1;
            hit   = i;
         end
         if (i != 0 && nf == 0 && dir_ids[i] == FREE_ID) nf = i;
      end
      r.status       = ST_OK;
      r.byte_address = '0;
      r.next_free    = NF_W'(nf);
      if (rq.opcode == OP_LOAD) begin
         if (int'(rq.slot) >= NUM_SLOTS) begin
            r.status = ST_INVALID;
         end else begin
            dir_ids[rq.slot] = rq.block_id;
            r.byte_address   = ADDR_W'(int'(rq.slot) * SLOT_BYTES);
         end
      end else if (rq.block_id == FREE_ID) begin
         r.status    = ST_INVALID;
         r.next_free = '0;
      end else if (found) begin
         r.byte_address = ADDR_W'(hit * SLOT_BYTES);
      end else if (rq.opcode == OP_WRITE) begin
         if (nf == 0) begin
            r.status = ST_FULL;
         end else begin
            dir_ids[nf]    = rq.block_id;
            r.byte_address = ADDR_W'(nf * SLOT_BYTES);
         end
      end else begin
         r.status = ST_MISSING;
      end
      return r;
   endfunction

   task automatic queue_req(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [SLOT_W-1:0] slot);
      dir_req_type rq;
      rq.opcode   = op;
      rq.block_id = id;
      rq.slot     = slot;
      pending_reqs.push_back(rq);
   endtask

   // small id pool so that hits and duplicates are common
   function automatic logic [ID_W-1:0] pick_pool_id();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return FREE_ID;
      if (sel == 1) return 16'hFFFE;
      if (sel == 2) return 16'($urandom);
      return ID_W'(sel * 16'h1111 + 16'h0100);
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_opcode();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return OP_LOOKUP;
      if (sel < 7) return OP_WRITE;
      if (sel < 9) return OP_LOAD;
      return OP_SPARE;
   endfunction

   task automatic report_mismatch(input string what, input dir_rsp_type exp_r,
                                  input dir_rsp_type act_r);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: %s: exp status %0d addr %0d nf %0d, got status %0d addr %0d nf %0d",
                  $time, what, exp_r.status, exp_r.byte_address, exp_r.next_free,
                  act_r.status, act_r.byte_address, act_r.next_free);
      mismatch_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: predicts on each transfer, then offers the next item in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = 4;
         for (int i = 0; i < NUM_SLOTS; i++) dir_ids[i] = FREE_ID;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(resolve_request(pending_reqs[0]));
            pending_reqs.delete(0);
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid    <= 1'b1;
               req_opcode   <= pending_reqs[0].opcode;
               req_block_id <= pending_reqs[0].block_id;
               req_slot     <= pending_reqs[0].slot;
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 3) == 0) begin
                     gap_left   = 0;
                     burst_left = $urandom_range(20, 60);
                  end else begin
                     gap_left   = $urandom_range(1, 90);
                     burst_left = $urandom_range(1, 6);
                  end
               end
            end
         end
      end
   end

   // monitor: checks each result transfer and drives the stall pattern
   always @(posedge clock) begin
      dir_rsp_type act_r;
      dir_rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            act_r.status       = rsp_status;
            act_r.byte_address = rsp_byte_address;
            act_r.next_free    = rsp_next_free;
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", '0, act_r);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (exp_r.status != act_r.status || exp_r.byte_address != act_r.byte_address
                   || exp_r.next_free != act_r.next_free)
                  report_mismatch("mismatch", exp_r, act_r);
            end
         end
         rx_cycle++;
         if (rx_cycle % 40 == 0) rx_mode = $urandom_range(0, 3);
         if (holdoff_left == 0 && rsp_count >= next_holdoff_at) begin
            holdoff_left    = HOLDOFF_CYCLES;
            next_holdoff_at += 500;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rx_cycle % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int sel;
      int base;
      int k;
      // directed
      queue_req(OP_LOOKUP, FREE_ID, 6'd0);
      queue_req(OP_WRITE, FREE_ID, 6'd63);
      queue_req(OP_LOOKUP, 16'h0000, 6'd0);
      queue_req(OP_WRITE, 16'h0000, 6'd0);
      queue_req(OP_WRITE, 16'h0000, 6'd0);
      queue_req(OP_WRITE, 16'hFFFE, 6'd0);
      queue_req(OP_LOOKUP, 16'hFFFE, 6'd0);
      queue_req(OP_LOAD, 16'h1234, 6'd0);
      queue_req(OP_LOOKUP, 16'h1234, 6'd0);
      queue_req(OP_LOAD, 16'h0000, 6'd63);
      queue_req(OP_LOOKUP, 16'h0000, 6'd0);
      queue_req(OP_SPARE, 16'h0000, 6'd0);
      queue_req(OP_SPARE, 16'hAAAA, 6'd21);
      queue_req(OP_LOAD, FREE_ID, 6'd1);
      queue_req(OP_WRITE, 16'h5555, 6'd42);
      queue_req(OP_LOAD, FREE_ID, 6'd63);
      queue_req(OP_LOOKUP, 16'h5555, 6'd0);
      queue_req(OP_LOAD, 16'h8001, 6'd42);
      queue_req(OP_WRITE, 16'h8001, 6'd0);
      queue_req(OP_LOAD, 16'h2A2A, 6'd21);
      queue_req(OP_LOAD, FREE_ID, 6'd0);
      queue_req(OP_LOOKUP, 16'h7FFF, 6'd0);
      // random sequences
      while (pending_reqs.size() < REQ_TARGET) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) begin
            // fill the directory with fresh ids, more writes than it has slots, so that it reports full
            base = $urandom_range(0, 16'hFF00);
            for (k = 0; k < NUM_SLOTS + 4; k++)
               queue_req(OP_WRITE, ID_W'(base + k), 6'($urandom));
         end else if (sel == 2) begin
            for (k = 0; k < NUM_SLOTS; k++) queue_req(OP_LOAD, FREE_ID, SLOT_W'(k));
         end else if (sel == 3) begin
            for (k = 0; k < 15; k++)
               queue_req(OPCODE_W'($urandom), ID_W'($urandom), SLOT_W'($urandom));
         end else begin
            for (k = 0; k < 25; k++)
               queue_req(pick_opcode(), pick_pool_id(), SLOT_W'($urandom_range(0, 63)));
         end
      end
      @(negedge reset);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/bdla_pkg.sv
rtl/bdla_cell.sv
rtl/bdla_ctrl.sv
rtl/block_directory_lookup_alloc.sv
tb/tb_top.sv
